### rtl/ace_pkg.sv
// Package for the accumulator machine execute block.
// Holds the architectural state type, the memory write request and the opcode codes.
// No dependencies.
package ace_pkg;

  localparam int unsigned NUM_REGS = 4;

  typedef logic [7:0] byte_t;
  typedef logic [$clog2(NUM_REGS)-1:0] reg_idx_t;

  typedef struct packed {
    byte_t                     pc;
    byte_t                     acc;
    logic [NUM_REGS-1:0][7:0]  regs;
    byte_t                     sp;
    logic                      c;
    logic                      z;
    logic                      v;
    logic                      n;
  } arch_t;

  typedef struct packed {
    logic  en;
    byte_t addr;
    byte_t data;
  } mem_wr_t;

  localparam byte_t OP_NOP = 8'h00;
  localparam byte_t OP_RET = 8'h05;
  localparam byte_t OP_STC = 8'h0A;
  localparam byte_t OP_CLC = 8'h0F;

  localparam logic [3:0] HI_SYS = 4'h0;
  localparam logic [2:0] HI_ALU = 3'b010;

  localparam logic [5:0] PFX_LDI     = 6'h04;
  localparam logic [5:0] PFX_LDD     = 6'h06;
  localparam logic [5:0] PFX_STD     = 6'h07;
  localparam logic [5:0] PFX_MOV_RA  = 6'h08;
  localparam logic [5:0] PFX_MOV_AR  = 6'h09;
  localparam logic [5:0] PFX_POP     = 6'h0A;
  localparam logic [5:0] PFX_PUSH    = 6'h0B;
  localparam logic [5:0] PFX_MOV_RSP = 6'h0C;
  localparam logic [5:0] PFX_MOV_SPR = 6'h0D;
  localparam logic [5:0] PFX_LDS     = 6'h0E;
  localparam logic [5:0] PFX_STS     = 6'h0F;

  typedef enum logic [2:0] {
    ALU_ADD = 3'd0,
    ALU_SUB = 3'd1,
    ALU_ADC = 3'd2,
    ALU_SBB = 3'd3,
    ALU_XOR = 3'd4,
    ALU_AND = 3'd5,
    ALU_OR  = 3'd6,
    ALU_CMP = 3'd7
  } alu_op_t;

  localparam byte_t PC_STEP1 = 8'd1;
  localparam byte_t PC_STEP2 = 8'd2;

endpackage

### rtl/ace_if.sv
// Valid/ready channel interfaces for the instruction requests and the state results.
// Depends on ace_pkg.
interface ace_in_if;
  logic           valid;
  logic           ready;
  ace_pkg::byte_t opcode;
  ace_pkg::byte_t operand_byte;

  modport source (output valid, output opcode, output operand_byte, input ready);
  modport sink (input valid, input opcode, input operand_byte, output ready);
endinterface

interface ace_out_if;
  logic           valid;
  logic           ready;
  ace_pkg::byte_t next_pc;
  ace_pkg::byte_t acc_out;
  ace_pkg::byte_t reg0_out;
  ace_pkg::byte_t reg1_out;
  ace_pkg::byte_t reg2_out;
  ace_pkg::byte_t reg3_out;
  ace_pkg::byte_t stack_out;
  logic           carry_out;
  logic           zero_out;
  logic           overflow_out;
  logic           negative_out;
  logic           status;

  modport source (output valid, output next_pc, output acc_out, output reg0_out,
                  output reg1_out, output reg2_out, output reg3_out, output stack_out,
                  output carry_out, output zero_out, output overflow_out,
                  output negative_out, output status, input ready);
  modport sink (input valid, input next_pc, input acc_out, input reg0_out,
                input reg1_out, input reg2_out, input reg3_out, input stack_out,
                input carry_out, input zero_out, input overflow_out,
                input negative_out, input status, output ready);
endinterface

### rtl/accumulator_cpu_execute.sv
// Top level of the accumulator machine execute block.
// Depends on ace_pkg, ace_if, ace_dmem and ace_exec.
//
// Each request on in_ch carries an opcode and the program byte after it; each
// result on out_ch shows the machine state after that instruction, with
// status set for an undefined opcode, which changes nothing.
// A request is taken into the first stage, where the data memory address is
// formed and the synchronous memory is read. In the second stage the read data
// is used, the registers and flags are updated and any memory write is made;
// the result is then held in the output register until out_ch accepts it.
// A result passes through the second-stage register and then the output register before
// out_ch.valid rises; while the receiver does not stall, a new request
// can be taken every cycle. The stack pointer of an instruction finishing in
// the second stage is forwarded to the address of the next one, and a memory
// write to the address being read is bypassed inside the memory.
// When the receiver stalls, the second stage holds and in_ch.ready falls.
// Reset clears the program counter, accumulator, general registers, stack
// pointer, flags and all valid bits; the data memory is left as it is and
// must be written before it is read.
module accumulator_cpu_execute (
  input logic       clk,
  input logic       rst_n,
  ace_in_if.sink    in_ch,
  ace_out_if.source out_ch
);
  import ace_pkg::*;

  arch_t   arch_r;
  arch_t   arch_nxt;
  arch_t   out_st_r;
  logic    out_status_r;
  logic    out_v_r;
  logic    s2_v_r;
  byte_t   s2_op_r;
  byte_t   s2_imm_r;
  logic    commit;
  logic    accept;
  logic    ex_illegal;
  mem_wr_t ex_wr;
  mem_wr_t mem_wr;
  byte_t   sp_fwd;
  byte_t   rd_addr;
  byte_t   rd_data;

  assign commit      = s2_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s2_v_r || commit;
  assign accept      = in_ch.valid && in_ch.ready;
  assign sp_fwd      = commit ? arch_nxt.sp : arch_r.sp;

  always_comb begin
    case (in_ch.opcode[7:2])
      PFX_LDD: rd_addr = in_ch.operand_byte;
      PFX_POP: rd_addr = sp_fwd;
      PFX_LDS: rd_addr = sp_fwd + in_ch.operand_byte;
      default: rd_addr = (in_ch.opcode == OP_RET) ? sp_fwd : in_ch.operand_byte;
    endcase
  end

  always_comb begin
    mem_wr    = ex_wr;
    mem_wr.en = ex_wr.en && commit;
  end

  ace_dmem u_dmem (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ace_exec u_exec (
    .st       (arch_r),
    .opcode   (s2_op_r),
    .imm      (s2_imm_r),
    .mem_data (rd_data),
    .nx       (arch_nxt),
    .wr       (ex_wr),
    .illegal  (ex_illegal)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arch_r  <= '0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (accept) begin
        s2_v_r <= 1'b1;
      end else if (commit) begin
        s2_v_r <= 1'b0;
      end
      if (commit) begin
        arch_r  <= arch_nxt;
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_op_r  <= in_ch.opcode;
      s2_imm_r <= in_ch.operand_byte;
    end
    if (commit) begin
      out_st_r     <= arch_nxt;
      out_status_r <= ex_illegal;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.next_pc      = out_st_r.pc;
  assign out_ch.acc_out      = out_st_r.acc;
  assign out_ch.reg0_out     = out_st_r.regs[0];
  assign out_ch.reg1_out     = out_st_r.regs[1];
  assign out_ch.reg2_out     = out_st_r.regs[2];
  assign out_ch.reg3_out     = out_st_r.regs[3];
  assign out_ch.stack_out    = out_st_r.sp;
  assign out_ch.carry_out    = out_st_r.c;
  assign out_ch.zero_out     = out_st_r.z;
  assign out_ch.overflow_out = out_st_r.v;
  assign out_ch.negative_out = out_st_r.n;
  assign out_ch.status       = out_status_r;

`ifndef SYNTHESIS
  a_illegal_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    commit && ex_illegal |=> arch_r == $past(arch_r))
    else $error("An illegal opcode changed the machine state.");

  a_illegal_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    ex_illegal |-> !ex_wr.en)
    else $error("An illegal opcode requested a memory write.");

  a_commit_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_v_r && out_st_r == arch_r)
    else $error("A finished instruction did not reach the output register.");

  a_stalled_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && !commit |=> s2_v_r && $stable(s2_op_r) && $stable(s2_imm_r))
    else $error("A stalled instruction was lost or altered.");
`endif

endmodule

### rtl/ace_dmem.sv
// 256-byte data memory with one write port and one registered read port.
// A read of the address being written in the same cycle returns the new data.
// Depends on ace_pkg.
module ace_dmem (
  input  logic             clk,
  input  ace_pkg::mem_wr_t wr,
  input  logic             rd_en,
  input  ace_pkg::byte_t   rd_addr,
  output ace_pkg::byte_t   rd_data
);
  import ace_pkg::*;

  byte_t mem [0:255];
  byte_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= (wr.en && (wr.addr == rd_addr)) ? wr.data : mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/ace_exec.sv
// Decode and execute of one instruction: next architectural state and memory write.
// Depends on ace_pkg.
module ace_exec (
  input  ace_pkg::arch_t   st,
  input  ace_pkg::byte_t   opcode,
  input  ace_pkg::byte_t   imm,
  input  ace_pkg::byte_t   mem_data,
  output ace_pkg::arch_t   nx,
  output ace_pkg::mem_wr_t wr,
  output logic             illegal
);
  import ace_pkg::*;

  reg_idx_t    r;
  reg_idx_t    d;
  alu_op_t     aop;
  byte_t       a;
  byte_t       b;
  logic        cin;
  logic [8:0]  sum9;
  logic [8:0]  diff9;
  logic        add_v;
  logic        sub_v;
  byte_t       pc_step;
  logic        jumped;

  assign r   = opcode[1:0];
  assign d   = opcode[3:2];
  assign aop = alu_op_t'(opcode[4:2]);
  assign a   = st.acc;
  assign b   = st.regs[r];
  assign cin = ((aop == ALU_ADC) || (aop == ALU_SBB)) ? st.c : 1'b0;

  assign sum9  = {1'b0, a} + {1'b0, b} + {8'd0, cin};
  assign diff9 = {1'b0, a} - {1'b0, b} - {8'd0, cin};
  assign add_v = (a[7] ^ sum9[7]) & (b[7] ^ sum9[7]);
  assign sub_v = (a[7] ^ b[7]) & (a[7] ^ diff9[7]);

  always_comb begin
    nx       = st;
    wr.en    = 1'b0;
    wr.addr  = imm;
    wr.data  = st.regs[r];
    illegal  = 1'b0;
    jumped   = 1'b0;
    pc_step  = PC_STEP1;
    if (opcode[7:4] == HI_SYS) begin
      case (opcode)
        OP_NOP: begin
        end
        OP_RET: begin
          nx.pc  = mem_data;
          nx.sp  = st.sp + 8'd1;
          jumped = 1'b1;
        end
        OP_STC: nx.c = 1'b1;
        OP_CLC: nx.c = 1'b0;
        default: nx.regs[d] = st.regs[r];
      endcase
    end else if (opcode[7:5] == HI_ALU) begin
      case (aop)
        ALU_ADD, ALU_ADC: begin
          nx.acc = sum9[7:0];
          nx.c   = sum9[8];
          nx.v   = add_v;
          nx.z   = (sum9[7:0] == 8'd0);
          nx.n   = sum9[7];
        end
        ALU_SUB, ALU_SBB, ALU_CMP: begin
          if (aop != ALU_CMP) begin
            nx.acc = diff9[7:0];
          end
          nx.c = diff9[8];
          nx.v = sub_v;
          nx.z = (diff9[7:0] == 8'd0);
          nx.n = diff9[7];
        end
        ALU_XOR: begin
          nx.acc = a ^ b;
          nx.z   = ((a ^ b) == 8'd0);
          nx.n   = a[7] ^ b[7];
        end
        ALU_AND: begin
          nx.acc = a & b;
          nx.z   = ((a & b) == 8'd0);
          nx.n   = a[7] & b[7];
        end
        ALU_OR: begin
          nx.acc = a | b;
          nx.z   = ((a | b) == 8'd0);
          nx.n   = a[7] | b[7];
        end
        default: begin
        end
      endcase
    end else begin
      case (opcode[7:2])
        PFX_LDI: begin
          nx.regs[r] = imm;
          pc_step    = PC_STEP2;
        end
        PFX_LDD: begin
          nx.regs[r] = mem_data;
          pc_step    = PC_STEP2;
        end
        PFX_STD: begin
          wr.en   = 1'b1;
          pc_step = PC_STEP2;
        end
        PFX_MOV_RA:  nx.regs[r] = st.acc;
        PFX_MOV_AR:  nx.acc = st.regs[r];
        PFX_POP: begin
          nx.regs[r] = mem_data;
          nx.sp      = st.sp + 8'd1;
        end
        PFX_PUSH: begin
          nx.sp   = st.sp - 8'd1;
          wr.en   = 1'b1;
          wr.addr = st.sp - 8'd1;
        end
        PFX_MOV_RSP: nx.regs[r] = st.sp;
        PFX_MOV_SPR: nx.sp = st.regs[r];
        PFX_LDS: begin
          nx.regs[r] = mem_data;
          pc_step    = PC_STEP2;
        end
        PFX_STS: begin
          wr.en   = 1'b1;
          wr.addr = st.sp + imm;
          pc_step = PC_STEP2;
        end
        default: illegal = 1'b1;
      endcase
    end
    if (!illegal && !jumped) begin
      nx.pc = st.pc + pc_step;
    end
  end

endmodule

### dv/ace_state_checker.sv
// Checker for the accumulator machine execute block: predicts the machine state after each
// accepted request and compares it field by field with the results on the output channel.
// Depends on ace_pkg and the channel interfaces in ace_if.
module ace_state_checker (
  input  logic clk,
  input  logic rst_n,
  ace_in_if    in_mon,
  ace_out_if   out_mon,
  output int   mismatch_count,
  output int   pending_states
);
  timeunit 1ns;
  timeprecision 1ps;
  import ace_pkg::*;

  typedef struct packed {
    arch_t arch;
    logic  status;
  } machine_view_t;

  arch_t         mach;
  byte_t         dmem [256];
  machine_view_t expected_states [$];
  int            mismatches;

  function automatic logic execute_instruction(input byte_t op, input byte_t imm);
    reg_idx_t  r;
    reg_idx_t  d;
    byte_t     pc_step;
    byte_t     sp_addr;
    byte_t     a;
    byte_t     b;
    byte_t     res;
    logic [8:0] sum;
    logic      cin;
    logic      illegal;
    logic      jumped;
    alu_op_t   alu_sel;
    r       = op[1:0];
    d       = op[3:2];
    pc_step = PC_STEP1;
    sp_addr = mach.sp + imm;
    illegal = 1'b0;
    jumped  = 1'b0;
    if (op[7:4] == HI_SYS) begin
      case (op)
        OP_NOP: ;
        OP_RET: begin
          mach.pc = dmem[mach.sp];
          mach.sp = mach.sp + 8'd1;
          jumped  = 1'b1;
        end
        OP_STC: mach.c = 1'b1;
        OP_CLC: mach.c = 1'b0;
        default: mach.regs[d] = mach.regs[r];
      endcase
    end else if (op[7:5] == HI_ALU) begin
      a       = mach.acc;
      b       = mach.regs[r];
      alu_sel = alu_op_t'(op[4:2]);
      case (alu_sel)
        ALU_ADD, ALU_ADC: begin
          cin      = (alu_sel == ALU_ADC) ? mach.c : 1'b0;
          sum      = {1'b0, a} + {1'b0, b} + {8'd0, cin};
          mach.c   = sum[8];
          mach.v   = (a[7] == b[7]) && (sum[7] != a[7]);
          mach.z   = (sum[7:0] == 8'd0);
          mach.n   = sum[7];
          mach.acc = sum[7:0];
        end
        ALU_SUB, ALU_SBB, ALU_CMP: begin
          cin    = (alu_sel == ALU_SBB) ? mach.c : 1'b0;
          res    = a - b - {7'd0, cin};
          mach.c = ({1'b0, a} < ({1'b0, b} + {8'd0, cin}));
          mach.v = (a[7] != b[7]) && (res[7] != a[7]);
          mach.z = (res == 8'd0);
          mach.n = res[7];
          if (alu_sel != ALU_CMP) begin
            mach.acc = res;
          end
        end
        default: begin
          case (alu_sel)
            ALU_XOR: res = a ^ b;
            ALU_AND: res = a & b;
            default: res = a | b;
          endcase
          mach.acc = res;
          mach.z   = (res == 8'd0);
          mach.n   = res[7];
        end
      endcase
    end else begin
      case (op[7:2])
        PFX_LDI: begin
          mach.regs[r] = imm;
          pc_step      = PC_STEP2;
        end
        PFX_LDD: begin
          mach.regs[r] = dmem[imm];
          pc_step      = PC_STEP2;
        end
        PFX_STD: begin
          dmem[imm] = mach.regs[r];
          pc_step   = PC_STEP2;
        end
        PFX_MOV_RA: mach.regs[r] = mach.acc;
        PFX_MOV_AR: mach.acc = mach.regs[r];
        PFX_POP: begin
          mach.regs[r] = dmem[mach.sp];
          mach.sp      = mach.sp + 8'd1;
        end
        PFX_PUSH: begin
          mach.sp       = mach.sp - 8'd1;
          dmem[mach.sp] = mach.regs[r];
        end
        PFX_MOV_RSP: mach.regs[r] = mach.sp;
        PFX_MOV_SPR: mach.sp = mach.regs[r];
        PFX_LDS: begin
          mach.regs[r] = dmem[sp_addr];
          pc_step      = PC_STEP2;
        end
        PFX_STS: begin
          dmem[sp_addr] = mach.regs[r];
          pc_step       = PC_STEP2;
        end
        default: illegal = 1'b1;
      endcase
    end
    if (!illegal && !jumped) begin
      mach.pc = mach.pc + pc_step;
    end
    return illegal;
  endfunction

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    machine_view_t want;
    machine_view_t seen;
    if (!rst_n) begin
      mach       = '0;
      mismatches = 0;
      foreach (dmem[i]) begin
        dmem[i] = '0;
      end
      expected_states.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_states.size() == 0) begin
          mismatches++;
          $display("%0t: result with no request outstanding, expected none, got next_pc %0h",
                   $time, out_mon.next_pc);
        end else begin
          want = expected_states.pop_front();
          check_field("next_pc", want.arch.pc, out_mon.next_pc);
          check_field("acc_out", want.arch.acc, out_mon.acc_out);
          check_field("reg0_out", want.arch.regs[0], out_mon.reg0_out);
          check_field("reg1_out", want.arch.regs[1], out_mon.reg1_out);
          check_field("reg2_out", want.arch.regs[2], out_mon.reg2_out);
          check_field("reg3_out", want.arch.regs[3], out_mon.reg3_out);
          check_field("stack_out", want.arch.sp, out_mon.stack_out);
          check_field("carry_out", want.arch.c, out_mon.carry_out);
          check_field("zero_out", want.arch.z, out_mon.zero_out);
          check_field("overflow_out", want.arch.v, out_mon.overflow_out);
          check_field("negative_out", want.arch.n, out_mon.negative_out);
          check_field("status", want.status, out_mon.status);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        seen.status = execute_instruction(in_mon.opcode, in_mon.operand_byte);
        seen.arch   = mach;
        expected_states.push_back(seen);
      end
    end
    mismatch_count <= mismatches;
    pending_states <= expected_states.size();
  end

endmodule

### dv/tb_accumulator_cpu_execute.sv
// Top of the testbench for the accumulator machine execute block: clock, reset, instruction
// requests and result back-pressure, with the verdict taken from ace_state_checker.
// Depends on ace_pkg, ace_if, accumulator_cpu_execute and ace_state_checker.
module tb_accumulator_cpu_execute;
  timeunit 1ns;
  timeprecision 1ps;
  import ace_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned LONG_HOLD    = 150;
  localparam int unsigned HOLD_AFTER   = 150;
  localparam int unsigned RANDOM_ITEMS = 100;

  localparam reg_idx_t GR0 = 2'd0;
  localparam reg_idx_t GR1 = 2'd1;
  localparam reg_idx_t GR2 = 2'd2;
  localparam reg_idx_t GR3 = 2'd3;

  localparam byte_t OP_HOLE_FIRST  = 8'h14;
  localparam byte_t OP_HOLE_LAST   = 8'h17;
  localparam byte_t OP_UNDEF_FIRST = 8'h60;
  localparam byte_t OP_UNDEF_LAST  = 8'hFF;

  logic        clk = 1'b0;
  logic        rst_n;
  int          mismatch_count;
  int          pending_states;
  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;

  ace_in_if  in_ch ();
  ace_out_if out_ch ();

  accumulator_cpu_execute DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ace_state_checker state_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_count (mismatch_count),
    .pending_states (pending_states)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic issue_instruction(input byte_t op, input byte_t imm);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(16, 1);
      gap        = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.operand_byte <= imm;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  // The receiver alternates between stretches of free flow and stretches of random stalls,
  // with one long hold-off so that the pipeline fills and the request side backs up.
  initial begin
    int unsigned stretch;
    bit          stalling;
    bit          held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (!held && items_sent >= HOLD_AFTER) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      stretch  = $urandom_range(40, 5);
      stalling = ($urandom_range(2, 0) != 0);
      repeat (stretch) begin
        out_ch.ready <= stalling ? ($urandom_range(3, 0) != 0) : 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    byte_t op;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.opcode       <= OP_NOP;
    in_ch.operand_byte <= 8'h00;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Every data memory byte is written before any instruction can read it.
    for (int addr = 0; addr < 256; addr++) begin
      if ($urandom_range(3, 0) == 0) begin
        issue_instruction({PFX_LDI, reg_idx_t'($urandom_range(3, 0))},
                          byte_t'($urandom_range(255, 0)));
      end
      issue_instruction({PFX_STD, reg_idx_t'($urandom_range(3, 0))}, byte_t'(addr));
    end

    issue_instruction({PFX_LDI, GR0}, 8'hFF);
    issue_instruction({PFX_LDI, GR1}, 8'h01);
    issue_instruction({PFX_MOV_AR, GR0}, 8'h00);
    issue_instruction({HI_ALU, ALU_ADD, GR1}, 8'h00);
    issue_instruction({PFX_LDI, GR2}, 8'h7F);
    issue_instruction({PFX_MOV_AR, GR2}, 8'hFF);
    issue_instruction({HI_ALU, ALU_ADD, GR1}, 8'h00);
    issue_instruction({HI_ALU, ALU_SUB, GR1}, 8'h00);
    issue_instruction(OP_STC, 8'h00);
    issue_instruction({HI_ALU, ALU_ADC, GR0}, 8'h00);
    issue_instruction({HI_ALU, ALU_SBB, GR0}, 8'h00);
    issue_instruction(OP_CLC, 8'hFF);
    issue_instruction({HI_ALU, ALU_XOR, GR0}, 8'h00);
    issue_instruction({HI_ALU, ALU_AND, GR2}, 8'h00);
    issue_instruction({HI_ALU, ALU_OR, GR1}, 8'h00);
    issue_instruction({HI_ALU, ALU_CMP, GR0}, 8'h00);
    issue_instruction({HI_SYS, GR3, GR0}, 8'h00);
    issue_instruction(OP_NOP, 8'hFF);
    issue_instruction({PFX_MOV_RA, GR1}, 8'h00);
    issue_instruction({PFX_MOV_SPR, GR0}, 8'h00);
    issue_instruction({PFX_PUSH, GR2}, 8'h00);
    issue_instruction({PFX_POP, GR3}, 8'h00);
    issue_instruction({PFX_LDS, GR1}, 8'hFF);
    issue_instruction({PFX_STS, GR2}, 8'h80);
    issue_instruction({PFX_LDD, GR2}, 8'hFF);
    issue_instruction({PFX_STD, GR3}, 8'h00);
    issue_instruction({PFX_MOV_RSP, GR0}, 8'h00);
    issue_instruction(OP_RET, 8'h00);
    issue_instruction({PFX_PUSH, GR0}, 8'h00);
    issue_instruction(OP_HOLE_FIRST, 8'h00);
    issue_instruction(OP_HOLE_LAST, 8'hFF);
    issue_instruction(OP_UNDEF_FIRST, 8'h00);
    issue_instruction(OP_UNDEF_LAST, 8'hFF);

    repeat (RANDOM_ITEMS) begin
      if ($urandom_range(9, 0) == 0) begin
        op = byte_t'($urandom_range(OP_UNDEF_LAST, OP_UNDEF_FIRST));
      end else begin
        op = byte_t'($urandom_range(OP_UNDEF_FIRST - 1, 0));
      end
      issue_instruction(op, byte_t'($urandom_range(255, 0)));
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_states != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_states == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### accumulator_cpu_execute.f
rtl/ace_pkg.sv
rtl/ace_if.sv
rtl/ace_dmem.sv
rtl/ace_exec.sv
rtl/accumulator_cpu_execute.sv
dv/ace_state_checker.sv
dv/tb_accumulator_cpu_execute.sv
